// ===== rtl/unix_seconds_to_calendar_unit_macros.svh =====
// Assertion macros shared by the calendar conversion RTL.
`ifndef UNIX_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define UNIX_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define UCAL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define UCAL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UCAL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define UCAL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/ucal_pkg.sv =====
// Types, constants and helpers for the seconds-to-calendar converter.
package ucal_pkg;

    localparam int SECONDS_BITS = 37;
    localparam int EPOCH_YEAR   = 1970;

    // 86400 > 2**16, so the day count needs 16 bits fewer than the seconds.
    localparam int DAY_W  = SECONDS_BITS - 16;
    localparam int DCMP_W = (DAY_W > 18) ? DAY_W : 18;

    localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [17:0] CYCLE_DAYS    = 18'd146097;
    localparam logic [12:0] CYCLE_YEARS   = 13'd400;
    localparam logic [12:0] YEAR_INIT     = 13'(EPOCH_YEAR);
    localparam logic [8:0]  MOD400_INIT   = 9'(EPOCH_YEAR % 400);
    localparam logic [6:0]  MOD100_INIT   = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0]  MOD400_LAST   = 9'd399;
    localparam logic [6:0]  MOD100_LAST   = 7'd99;

    // A day is 2**7 * 675 seconds. The low seven bits go straight into the time
    // of day and the rest is divided by 675 with a rounded-up reciprocal, which
    // is exact for every value of QIN_W bits since its error stays below 2**10.
    localparam int DAY_SHIFT   = 7;
    localparam int QIN_W       = SECONDS_BITS - DAY_SHIFT;
    localparam int RECIP_SHIFT = QIN_W + 10;
    localparam int RECIP_W     = QIN_W + 1;
    localparam int PROD_W      = QIN_W + RECIP_W;
    localparam logic [9:0] DAY_ODD = 10'd675;
    localparam logic [RECIP_W-1:0] DAY_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] HOURS_PER_DAY = 5'd24;

    localparam logic [4:0] MONTH_DAYS [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                               5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CYC,
        S_YEAR,
        S_MONTH,
        S_HOUR,
        S_MIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic cyc_step;
        logic year_step;
        logic month_step;
        logic hour_step;
        logic min_step;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic cyc_done;
        logic year_done;
        logic month_done;
        logic hour_done;
        logic min_done;
    } t_status;

    function automatic logic [4:0] f_month_len(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        idx = month - MONTH_JAN;
        if (month == MONTH_FEB && leap) begin
            return 5'd29;
        end
        return MONTH_DAYS[idx];
    endfunction

endpackage

// ===== rtl/unix_seconds_to_calendar_unit.sv =====
// Top level of the seconds-since-1970 to Gregorian date and time converter.
// One item at a time: the epoch seconds are taken when start is high and busy
// is low, and the result appears for exactly one cycle with o_valid. The
// seconds are first split into whole days and then the time of day, then the
// walks step once per 400-year cycle (up to 10), per elapsed year within the
// cycle (up to 399), per month, per hour and per minute, and the result state
// follows. The year walk takes the most steps; the longest case is the last
// day of a 400-year cycle reached after nine whole 400-year periods. busy drops in the
// cycle after o_valid; the receiver cannot stall, so the result must be
// captured in its strobe cycle.
module unix_seconds_to_calendar_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ucal_pkg::SECONDS_BITS-1:0] i_epoch_seconds,
    output logic                              o_valid,
    output logic [12:0]                       o_year,
    output logic [3:0]                        o_month,
    output logic [4:0]                        o_day_of_month,
    output logic [4:0]                        o_hour,
    output logic [5:0]                        o_minute,
    output logic [5:0]                        o_second
);
    import ucal_pkg::*;

    t_cmd    cmd;
    t_status status;

    ucal_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    ucal_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_epoch_seconds (i_epoch_seconds),
        .o_status        (status),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

endmodule

// ===== rtl/ucal_dp.sv =====
// Datapath: day division, year/month walk and time-of-day split.
`include "unix_seconds_to_calendar_unit_macros.svh"
module ucal_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ucal_pkg::t_cmd                i_cmd,
    input  logic [ucal_pkg::SECONDS_BITS-1:0] i_epoch_seconds,
    output ucal_pkg::t_status             o_status,
    output logic [12:0]                   o_year,
    output logic [3:0]                    o_month,
    output logic [4:0]                    o_day_of_month,
    output logic [4:0]                    o_hour,
    output logic [5:0]                    o_minute,
    output logic [5:0]                    o_second
);
    import ucal_pkg::*;

    logic [SECONDS_BITS-1:0] r_num;
    logic [16:0]             r_tod;
    logic [DAY_W-1:0]        r_days;
    logic                    r_div_phase;
    logic [12:0]             r_year;
    logic [8:0]              r_mod400;
    logic [6:0]              r_mod100;
    logic [3:0]              r_month;
    logic [4:0]              r_hour;
    logic [5:0]              r_min;

    logic [QIN_W-1:0]  day_num;
    logic [PROD_W-1:0] day_prod;
    logic [9:0]        day_sub;
    logic [DCMP_W-1:0] days_ext;
    logic              leap;
    logic [8:0]        ylen;
    logic [4:0]        mlen;

    assign day_num  = r_num[SECONDS_BITS-1:DAY_SHIFT];
    assign day_prod = PROD_W'(day_num) * PROD_W'(DAY_RECIP);
    // Only the low ten bits of days * 675 matter, since the remainder is below 675.
    assign day_sub  = r_days[9:0] * DAY_ODD;
    assign days_ext = DCMP_W'(r_days);
    assign leap     = (r_mod400 == 9'd0) || ((r_mod400[1:0] == 2'd0) && (r_mod100 != 7'd0));
    assign ylen     = leap ? 9'd366 : 9'd365;
    assign mlen     = f_month_len(r_month, leap);

    assign o_status.div_last   = r_div_phase;
    assign o_status.cyc_done   = days_ext < DCMP_W'(CYCLE_DAYS);
    assign o_status.year_done  = days_ext < DCMP_W'(ylen);
    assign o_status.month_done = days_ext < DCMP_W'(mlen);
    assign o_status.hour_done  = r_tod < SECS_PER_HOUR;
    assign o_status.min_done   = r_tod < SECS_PER_MIN;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num       <= i_epoch_seconds;
            r_tod       <= '0;
            r_days      <= '0;
            r_div_phase <= 1'b0;
            r_year      <= YEAR_INIT;
            r_mod400    <= MOD400_INIT;
            r_mod100    <= MOD100_INIT;
            r_month     <= MONTH_JAN;
            r_hour      <= '0;
            r_min       <= '0;
        end
        // Whole days by reciprocal multiply first, then the time of day from its low bits.
        if (i_cmd.div_step) begin
            if (!r_div_phase) begin
                r_days <= day_prod[RECIP_SHIFT +: DAY_W];
            end else begin
                r_tod <= {r_num[DAY_SHIFT +: 10] - day_sub, r_num[DAY_SHIFT-1:0]};
            end
            r_div_phase <= 1'b1;
        end
        if (i_cmd.cyc_step) begin
            r_days <= DAY_W'(days_ext - DCMP_W'(CYCLE_DAYS));
            r_year <= r_year + CYCLE_YEARS;
        end
        if (i_cmd.year_step) begin
            r_days   <= DAY_W'(days_ext - DCMP_W'(ylen));
            r_year   <= r_year + 13'd1;
            r_mod400 <= (r_mod400 == MOD400_LAST) ? 9'd0 : r_mod400 + 9'd1;
            r_mod100 <= (r_mod100 == MOD100_LAST) ? 7'd0 : r_mod100 + 7'd1;
        end
        if (i_cmd.month_step) begin
            r_days  <= DAY_W'(days_ext - DCMP_W'(mlen));
            r_month <= r_month + 4'd1;
        end
        if (i_cmd.hour_step) begin
            r_tod  <= r_tod - SECS_PER_HOUR;
            r_hour <= r_hour + 5'd1;
        end
        if (i_cmd.min_step) begin
            r_tod <= r_tod - SECS_PER_MIN;
            r_min <= r_min + 6'd1;
        end
    end

    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = 5'(r_days) + 5'd1;
    assign o_hour         = r_hour;
    assign o_minute       = r_min;
    assign o_second       = r_tod[5:0];

    `UCAL_ASSERT_IMP(a_year_in_cycle, i_clk, i_rst_n, i_cmd.year_step,
        days_ext < DCMP_W'(CYCLE_DAYS), "year walk started before cycle reduction finished")
    `UCAL_ASSERT_IMP(a_month_in_year, i_clk, i_rst_n, i_cmd.month_step,
        r_month < MONTH_DEC, "month walk ran past December")
    `UCAL_ASSERT_IMP(a_hour_in_day, i_clk, i_rst_n, i_cmd.min_step,
        r_hour < HOURS_PER_DAY, "hour count left the day")

endmodule

// ===== rtl/ucal_ctrl.sv =====
// Controller: sequences division, 400-year cycle, year, month and time-of-day steps.
`include "unix_seconds_to_calendar_unit_macros.svh"
module ucal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ucal_pkg::t_status i_status,
    output ucal_pkg::t_cmd    o_cmd,
    output logic              o_busy,
    output logic              o_valid
);
    import ucal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CYC;
                end
            end
            S_CYC: begin
                if (i_status.cyc_done) begin
                    n_state = S_YEAR;
                end else begin
                    o_cmd.cyc_step = 1'b1;
                end
            end
            S_YEAR: begin
                if (i_status.year_done) begin
                    n_state = S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (i_status.month_done) begin
                    n_state = S_HOUR;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            S_HOUR: begin
                if (i_status.hour_done) begin
                    n_state = S_MIN;
                end else begin
                    o_cmd.hour_step = 1'b1;
                end
            end
            S_MIN: begin
                if (i_status.min_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.min_step = 1'b1;
                end
            end
            S_DONE: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `UCAL_ASSERT_NXT(a_valid_then_idle, i_clk, i_rst_n, o_valid, !o_busy, "result beat not followed by idle")
    `UCAL_ASSERT_NXT(a_start_to_div, i_clk, i_rst_n, i_start && !o_busy, r_state == S_DIV, "accepted item did not enter division")
    `UCAL_ASSERT_NXT(a_div_to_cyc, i_clk, i_rst_n, o_cmd.div_step && i_status.div_last, r_state == S_CYC, "division end did not move to cycle reduction")

endmodule
